@@ rtl/bfu_pkg.sv @@
`default_nettype none
package bfu_pkg;

    localparam int DIM_W     = 13;
    localparam int RGB_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] OUT_WIDTH_RESET  = 13'd320;
    localparam logic [DIM_W-1:0] OUT_HEIGHT_RESET = 13'd240;

    // Sideband that travels next to the coordinate dividers.
    typedef struct packed {
        logic             cmd;
        logic             filt;
        logic             inrange;
        logic [RGB_W-1:0] rgb;
    } side_t;

    // Per-channel weighted blend: (a*(256-f) + b*f) >> 8, truncated.
    function automatic logic [RGB_W-1:0] blend(input logic [RGB_W-1:0] a,
                                               input logic [RGB_W-1:0] b,
                                               input logic [7:0] f);
        logic [16:0]      acc;
        logic [8:0]       wa;
        logic [RGB_W-1:0] res;
        wa  = 9'd256 - {1'b0, f};
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 17'(a[8*ch +: 8]) * 17'(wa) + 17'(b[8*ch +: 8]) * 17'(f);
            res[8*ch +: 8] = acc[15:8];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bfu_div.sv @@
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// The caller guarantees that the quotient fits in QW bits.
module bfu_div #(
    parameter int NW = 42,
    parameter int QW = 26,
    parameter int DW = 13
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num_i,
    input  wire logic [DW-1:0] den_i,
    output logic      [QW-1:0] quo_o,
    output logic      [DW-1:0] rem_o
);

    logic [DW-1:0] r_reg  [QW];
    logic [QW-1:0] lo_reg [QW];
    logic [DW-1:0] d_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] r_in;
        logic [QW-1:0] lo_in;
        logic [DW-1:0] d_in;
        logic [DW:0]   t;
        logic          ge;
        logic [DW-1:0] r_next;
        logic [QW-1:0] lo_next;

        if (k == 0) begin : g_first
            assign r_in  = DW'(num_i >> QW);
            assign lo_in = num_i[QW-1:0];
            assign d_in  = den_i;
        end else begin : g_rest
            assign r_in  = r_reg[k-1];
            assign lo_in = lo_reg[k-1];
            assign d_in  = d_reg[k-1];
        end

        always_comb begin
            t       = {r_in, lo_in[QW-1]};
            ge      = (t >= {1'b0, d_in});
            r_next  = ge ? DW'(t - {1'b0, d_in}) : DW'(t);
            lo_next = {lo_in[QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]  <= r_next;
                lo_reg[k] <= lo_next;
                d_reg[k]  <= d_in;
            end
        end
    end

    assign quo_o = lo_reg[QW-1];
    assign rem_o = r_reg[QW-1];

endmodule
`default_nettype wire

@@ rtl/bilinear_frame_upscaler.sv @@
`default_nettype none
// Bilinear frame upscaler.
// Input stream (s_*): s_tuser selects a transaction kind. A load writes one
// pixel of the SRC_WIDTH x SRC_HEIGHT source frame and returns nothing; a
// request names an output pixel and returns one RGB pixel on m_*.
// Configuration (cfg_*): index 0 sets the output width, index 1 the output
// height; write only while no transaction is in flight.
// Throughput is one transaction per cycle while the output buffer has room.
// A request passes the input stage, the two bit-per-stage coordinate
// dividers, the addressing stage, the four-bank frame read and the two
// blend passes. The four banks split the frame by row and column parity,
// so the four neighbors are read in the same cycle.
// Reset empties the pipeline and sets the output size to 320 x 240; the
// frame contents stay undefined until loaded.
// A two-entry output buffer keeps taking results while the receiver stalls;
// only when both entries are held does the pipeline freeze and s_tready drop.
module bilinear_frame_upscaler #(
    parameter int SRC_WIDTH      = 320,
    parameter int SRC_HEIGHT     = 240,
    parameter int MAX_FILTER_DIM = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata from bit 0: src_index[16:0], src_rgb[40:17], out_x[53:41],
    // out_y[66:54], zero fill [71:67]
    input  wire logic [71:0] s_tdata,
    // s_tuser: cmd
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata from bit 0: out_rgb[23:0]
    output logic [23:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bfu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfu_pkg::DIM_W-1:0]     cfg_data
);
    import bfu_pkg::*;

    localparam int SMAX   = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int QW     = $clog2(SMAX) + 17;
    localparam int NW     = $clog2(SMAX + 1) + 29;
    localparam int CXW    = $clog2(SRC_WIDTH);
    localparam int CYW    = $clog2(SRC_HEIGHT);
    localparam int HW     = (SRC_WIDTH + 1) / 2;
    localparam int HH     = (SRC_HEIGHT + 1) / 2;
    localparam int BDEPTH = HW * HH;
    localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int FRAME  = SRC_WIDTH * SRC_HEIGHT;
    localparam logic [QW-1:0]  HALF_Q = QW'(1) << 15;
    localparam logic [QW-1:0]  MXX    = QW'(SRC_WIDTH - 1) << 16;
    localparam logic [QW-1:0]  MXY    = QW'(SRC_HEIGHT - 1) << 16;
    localparam logic [CXW-1:0] LASTX  = CXW'(SRC_WIDTH - 1);
    localparam logic [CYW-1:0] LASTY  = CYW'(SRC_HEIGHT - 1);

    logic en;

    // Configuration registers.
    logic [DIM_W-1:0] w_reg, h_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= OUT_WIDTH_RESET;
            h_reg <= OUT_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OUT_WIDTH:  w_reg <= cfg_data;
                CFG_OUT_HEIGHT: h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: clamp coordinates and classify the transaction.
    logic [DIM_W-1:0] w_eff, h_eff, in_x, in_y, x_cl, y_cl;
    logic [16:0]      in_idx;
    logic             in_filt, in_range;

    assign in_idx = s_tdata[16:0];
    assign in_x   = s_tdata[53:41];
    assign in_y   = s_tdata[66:54];

    always_comb begin
        w_eff    = (w_reg == '0) ? DIM_W'(1) : w_reg;
        h_eff    = (h_reg == '0) ? DIM_W'(1) : h_reg;
        x_cl     = (in_x >= w_eff) ? w_eff - DIM_W'(1) : in_x;
        y_cl     = (in_y >= h_eff) ? h_eff - DIM_W'(1) : in_y;
        in_filt  = !((32'(w_eff) > MAX_FILTER_DIM) || (32'(h_eff) > MAX_FILTER_DIM));
        in_range = (32'(in_idx) < FRAME);
    end

    logic             s0_vld_reg;
    side_t            s0_side_reg;
    logic [DIM_W-1:0] s0_x_reg, s0_y_reg, s0_w_reg, s0_h_reg;
    logic [16:0]      s0_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_side_reg.cmd     <= s_tuser;
            s0_side_reg.filt    <= in_filt;
            s0_side_reg.inrange <= in_range;
            s0_side_reg.rgb     <= s_tdata[40:17];
            s0_x_reg            <= x_cl;
            s0_y_reg            <= y_cl;
            s0_w_reg            <= w_eff;
            s0_h_reg            <= h_eff;
            s0_idx_reg          <= in_idx;
        end
    end

    // Numerators: a load splits its index into row and column, a filtered
    // request maps half-pixel centers in 16.16, a nearest request scales.
    logic [NW-1:0]    num_x, num_y;
    logic [DIM_W-1:0] den_x;

    always_comb begin
        if (s0_side_reg.cmd == CMD_LOAD) begin
            num_x = NW'(s0_idx_reg);
            num_y = '0;
            den_x = DIM_W'(SRC_WIDTH);
        end else if (s0_side_reg.filt) begin
            num_x = (NW'({s0_x_reg, 1'b1}) * NW'(SRC_WIDTH)) << 15;
            num_y = (NW'({s0_y_reg, 1'b1}) * NW'(SRC_HEIGHT)) << 15;
            den_x = s0_w_reg;
        end else begin
            num_x = NW'(s0_x_reg) * NW'(SRC_WIDTH);
            num_y = NW'(s0_y_reg) * NW'(SRC_HEIGHT);
            den_x = s0_w_reg;
        end
    end

    logic [QW-1:0]    qx, qy;
    logic [DIM_W-1:0] rx, ry;

    bfu_div #(.NW(NW), .QW(QW), .DW(DIM_W)) u_div_x (
        .aclk(aclk), .en(en), .num_i(num_x), .den_i(den_x), .quo_o(qx), .rem_o(rx)
    );

    bfu_div #(.NW(NW), .QW(QW), .DW(DIM_W)) u_div_y (
        .aclk(aclk), .en(en), .num_i(num_y), .den_i(s0_h_reg), .quo_o(qy), .rem_o(ry)
    );

    logic  dv_vld_reg  [QW];
    side_t dv_side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[k] <= (k == 0) ? s0_vld_reg : dv_vld_reg[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_side_reg[k] <= (k == 0) ? s0_side_reg : dv_side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Coordinate stage.
    side_t          dv_side;
    logic [QW-1:0]  fxq, fyq;
    logic [CXW-1:0] x0_next, x1_next;
    logic [CYW-1:0] y0_next, y1_next;
    logic [7:0]     fx_next, fy_next;

    assign dv_side = dv_side_reg[QW-1];

    always_comb begin
        fxq = (qx[QW-1:15] == '0) ? '0 : qx - HALF_Q;
        if (fxq > MXX) fxq = MXX;
        fyq = (qy[QW-1:15] == '0) ? '0 : qy - HALF_Q;
        if (fyq > MXY) fyq = MXY;
        if (dv_side.cmd == CMD_LOAD) begin
            x0_next = CXW'(rx);
            y0_next = CYW'(qx);
            fx_next = '0;
            fy_next = '0;
            x1_next = x0_next;
            y1_next = y0_next;
        end else if (dv_side.filt) begin
            x0_next = CXW'(fxq >> 16);
            y0_next = CYW'(fyq >> 16);
            fx_next = fxq[15:8];
            fy_next = fyq[15:8];
            x1_next = (x0_next < LASTX) ? x0_next + CXW'(1) : x0_next;
            y1_next = (y0_next < LASTY) ? y0_next + CYW'(1) : y0_next;
        end else begin
            x0_next = (qx > QW'(LASTX)) ? LASTX : CXW'(qx);
            y0_next = (qy > QW'(LASTY)) ? LASTY : CYW'(qy);
            fx_next = '0;
            fy_next = '0;
            x1_next = x0_next;
            y1_next = y0_next;
        end
    end

    logic           c1_vld_reg;
    side_t          c1_side_reg;
    logic [CXW-1:0] c1_x0_reg, c1_x1_reg;
    logic [CYW-1:0] c1_y0_reg, c1_y1_reg;
    logic [7:0]     c1_fx_reg, c1_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_vld_reg <= 1'b0;
        end else if (en) begin
            c1_vld_reg <= dv_vld_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_side_reg <= dv_side;
            c1_x0_reg   <= x0_next;
            c1_x1_reg   <= x1_next;
            c1_y0_reg   <= y0_next;
            c1_y1_reg   <= y1_next;
            c1_fx_reg   <= fx_next;
            c1_fy_reg   <= fy_next;
        end
    end

    // Bank addressing: bank {row parity, column parity}.
    logic [CYW-1:0] rs [2];
    logic [CXW-1:0] cs [2];
    logic [BAW-1:0] baddr [4];
    logic [1:0]     wbank;
    logic           we;

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            rs[p] = (c1_y0_reg[0] == p[0]) ? c1_y0_reg : c1_y1_reg;
            cs[p] = (c1_x0_reg[0] == p[0]) ? c1_x0_reg : c1_x1_reg;
        end
        for (int b = 0; b < 4; b++) begin
            baddr[b] = BAW'(32'(rs[b / 2] >> 1) * HW + 32'(cs[b % 2] >> 1));
        end
        wbank = {c1_y0_reg[0], c1_x0_reg[0]};
        we    = en && c1_vld_reg && (c1_side_reg.cmd == CMD_LOAD) && c1_side_reg.inrange;
    end

    logic [RGB_W-1:0] rd_reg [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [RGB_W-1:0] mem [BDEPTH];
        always_ff @(posedge aclk) begin
            if (en) begin
                if (we && (wbank == 2'(b))) begin
                    mem[baddr[b]] <= c1_side_reg.rgb;
                end
                rd_reg[b] <= mem[baddr[b]];
            end
        end
    end

    logic       c2_vld_reg;
    logic       c2_y0p_reg, c2_y1p_reg, c2_x0p_reg, c2_x1p_reg;
    logic [7:0] c2_fx_reg, c2_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_vld_reg <= 1'b0;
        end else if (en) begin
            c2_vld_reg <= c1_vld_reg && (c1_side_reg.cmd == CMD_REQUEST);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_y0p_reg <= c1_y0_reg[0];
            c2_y1p_reg <= c1_y1_reg[0];
            c2_x0p_reg <= c1_x0_reg[0];
            c2_x1p_reg <= c1_x1_reg[0];
            c2_fx_reg  <= c1_fx_reg;
            c2_fy_reg  <= c1_fy_reg;
        end
    end

    // Vertical blend of both columns.
    logic [RGB_W-1:0] left_next, right_next;

    always_comb begin
        left_next  = blend(rd_reg[{c2_y0p_reg, c2_x0p_reg}],
                           rd_reg[{c2_y1p_reg, c2_x0p_reg}], c2_fy_reg);
        right_next = blend(rd_reg[{c2_y0p_reg, c2_x1p_reg}],
                           rd_reg[{c2_y1p_reg, c2_x1p_reg}], c2_fy_reg);
    end

    logic             c3_vld_reg;
    logic [RGB_W-1:0] c3_left_reg, c3_right_reg;
    logic [7:0]       c3_fx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_vld_reg <= 1'b0;
        end else if (en) begin
            c3_vld_reg <= c2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c3_left_reg  <= left_next;
            c3_right_reg <= right_next;
            c3_fx_reg    <= c2_fx_reg;
        end
    end

    // Horizontal blend into a two-entry output buffer.
    logic [RGB_W-1:0] res;
    logic [1:0]       cnt_reg;
    logic [RGB_W-1:0] buf0_reg, buf1_reg;
    logic             push, pop;

    assign res      = blend(c3_left_reg, c3_right_reg, c3_fx_reg);
    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;
    assign push     = en && c3_vld_reg;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = buf0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && pop) begin
            if (cnt_reg == 2'd1) buf0_reg <= res;
            else begin
                buf0_reg <= buf1_reg;
                buf1_reg <= res;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) buf0_reg <= res;
            else buf1_reg <= res;
        end else if (pop) begin
            buf0_reg <= buf1_reg;
        end
    end

    a_write_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (32'(c1_y0_reg) < SRC_HEIGHT) && (32'(c1_x0_reg) < SRC_WIDTH))
        else $error("frame write outside the source frame");

    a_request_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (c1_vld_reg && (c1_side_reg.cmd == CMD_REQUEST)) |->
        (32'(c1_x1_reg) < SRC_WIDTH) && (32'(c1_y1_reg) < SRC_HEIGHT))
        else $error("request footprint outside the source frame");

    a_neighbor: assert property (@(posedge aclk) disable iff (!aresetn)
        c1_vld_reg |-> ((c1_x1_reg == c1_x0_reg) || (c1_x1_reg == c1_x0_reg + CXW'(1))) &&
                       ((c1_y1_reg == c1_y0_reg) || (c1_y1_reg == c1_y0_reg + CYW'(1))))
        else $error("neighbor pixel is not adjacent");

    a_buffer_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer overflow");

endmodule
`default_nettype wire
